// File: rtl/assert_macros.svh
// Assertion macros shared by the timer RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Whenever the trigger holds, the consequence holds in the cycle after.
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: rtl/ptt_pkg.sv
// Types and constants for the programmable tick timer.
// No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

	localparam int PRESCALE_W = 9;
	localparam int COUNT_W    = 8;

	typedef logic [PRESCALE_W-1:0] prescale_t;
	typedef logic [COUNT_W-1:0]    count_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TIMER_ENABLE = 2'd0,
		CFG_CLOCK_SELECT = 2'd1,
		CFG_MODULO_VALUE = 2'd2
	} cfg_idx_t;

	// Prescale select codes
	typedef enum logic [1:0] {
		SEL_DIV256 = 2'd0,
		SEL_DIV4   = 2'd1,
		SEL_DIV16  = 2'd2,
		SEL_DIV64  = 2'd3
	} clk_sel_t;

	localparam prescale_t DIVIDER_LIMIT = 9'd255;
	localparam count_t    COUNT_MAX     = 8'd255;

	function automatic prescale_t select_threshold(clk_sel_t sel);
		prescale_t thr;
		case (sel)
			SEL_DIV256: thr = 9'd256;
			SEL_DIV4:   thr = 9'd4;
			SEL_DIV16:  thr = 9'd16;
			SEL_DIV64:  thr = 9'd64;
			default:    thr = 9'd256;
		endcase
		return thr;
	endfunction

endpackage

// File: rtl/programmable_tick_timer_with_divider.sv
// Programmable tick timer with a free-running divider counter.
// Depends on ptt_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// Each accepted word carries the machine cycles elapsed since the previous
// word and returns one result word: timer value, divider value and the
// timer overflow flag for that word. The block takes one word per clock
// while the result channel is not stalled; an accepted word passes the
// input register, then the counter registers. The rate is set by the
// 9-bit prescale add and threshold compare feeding the counter registers.
// Configuration is written through the cfg channel, which is always ready;
// write it only while no word is in flight. Writes to index 3 are ignored.
`include "assert_macros.svh"

module programmable_tick_timer_with_divider (
	input  logic       clk,
	input  logic       arst_n,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] elapsed_cycles,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] timer_value,
	output logic [7:0] divider_value,
	output logic       timer_irq
);

	// configuration
	logic              timer_enable_q;
	ptt_pkg::clk_sel_t clock_select_q;
	ptt_pkg::count_t   modulo_value_q;

	// input stage
	logic              valid_s1;
	logic [7:0]        cycles_s1;

	// counter state, also the result word
	ptt_pkg::prescale_t timer_prescale_q;
	ptt_pkg::count_t    timer_count_q;
	ptt_pkg::prescale_t divider_prescale_q;
	ptt_pkg::count_t    divider_count_q;
	logic               irq_q;
	logic               out_valid_q;

	logic               advance;
	ptt_pkg::prescale_t timer_sum;
	ptt_pkg::prescale_t divider_sum;
	logic               timer_step;
	logic               divider_step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_enable_q <= 1'b0;
			clock_select_q <= ptt_pkg::SEL_DIV256;
			modulo_value_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptt_pkg::CFG_TIMER_ENABLE: timer_enable_q <= cfg_data[0];
				ptt_pkg::CFG_CLOCK_SELECT:
					clock_select_q <= ptt_pkg::clk_sel_t'(cfg_data[1:0]);
				ptt_pkg::CFG_MODULO_VALUE: modulo_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// move the input word into the counters when the result slot frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cycles_s1 <= elapsed_cycles;
		end
	end

	// accumulators stay at or below 256, so the 9-bit sum never wraps
	always_comb begin
		timer_sum    = timer_prescale_q + {1'b0, cycles_s1};
		divider_sum  = divider_prescale_q + {1'b0, cycles_s1};
		timer_step   = timer_sum > ptt_pkg::select_threshold(clock_select_q);
		divider_step = divider_sum > ptt_pkg::DIVIDER_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_prescale_q   <= '0;
			timer_count_q      <= '0;
			divider_prescale_q <= '0;
			divider_count_q    <= '0;
			irq_q              <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				irq_q <= timer_enable_q && timer_step &&
					(timer_count_q == ptt_pkg::COUNT_MAX);
				if (timer_enable_q) begin
					if (timer_step) begin
						timer_prescale_q <= '0;
						if (timer_count_q == ptt_pkg::COUNT_MAX) begin
							timer_count_q <= modulo_value_q;
						end else begin
							timer_count_q <= timer_count_q + 8'd1;
						end
					end else begin
						timer_prescale_q <= timer_sum;
					end
				end
				if (divider_step) begin
					divider_prescale_q <= '0;
					divider_count_q    <= divider_count_q + 8'd1;
				end else begin
					divider_prescale_q <= divider_sum;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign timer_value   = timer_count_q;
	assign divider_value = divider_count_q;
	assign timer_irq     = irq_q;

	`ASSERT_ALWAYS(a_timer_prescale_bound, timer_prescale_q <= 9'd256, "timer prescale above 256")
	`ASSERT_ALWAYS(a_divider_prescale_bound, divider_prescale_q <= ptt_pkg::DIVIDER_LIMIT, "divider prescale above 255")
	`ASSERT_ALWAYS(a_irq_reload, !(out_valid_q && irq_q) || timer_count_q == modulo_value_q, "irq without reload value")
	`ASSERT_NEXT(a_disabled_hold, advance && !timer_enable_q, timer_count_q == $past(timer_count_q) && !irq_q, "timer moved while disabled")

endmodule
